// ===== sv/cqss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cqss_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int VAL_W  = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SEARCH   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_TRAVERSE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SORT     = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_DELETE,
    OP_SEARCH,
    OP_TRAVERSE,
    OP_SORT,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] count;
  } bk_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TRAV_RD,
    S_TRAV_EMIT,
    S_SORT_EMIT,
    S_RESULT
  } bk_state_t;

endpackage

`default_nettype wire

// ===== sv/cqss_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cqss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/cqss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cqss_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [cqss_pkg::FUNC_W-1:0]        in_func,
  input  wire logic signed [cqss_pkg::VAL_W-1:0]  in_value,
  output logic                                    cmd_valid,
  output cqss_pkg::cmd_t                          cmd,
  input  wire logic                               cmd_take
);

  import cqss_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;
  op_t               op_dec;

  // classify the request
  always_comb begin
    unique case (in_func)
      FN_INSERT:   op_dec = OP_INSERT;
      FN_DELETE:   op_dec = OP_DELETE;
      FN_SEARCH:   op_dec = OP_SEARCH;
      FN_TRAVERSE: op_dec = OP_TRAVERSE;
      FN_SORT:     op_dec = OP_SORT;
      default:     op_dec = OP_NOP;
    endcase
  end

  assign in_stall  = (cnt_r == QCNT_W'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op_dec, value: in_value};
    end
  end

endmodule

`default_nettype wire

// ===== sv/cqss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cqss_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cmd_valid,
  input  wire cqss_pkg::cmd_t                     cmd,
  output logic                                    cmd_take,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [cqss_pkg::STAT_W-1:0]             out_status,
  output logic                                    out_found,
  output logic signed [cqss_pkg::VAL_W-1:0]       out_item_value,
  output logic                                    out_last,
  output cqss_pkg::bk_stat_t                      stat
);

  import cqss_pkg::*;

  bk_state_t               state_r, state_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic                    pend_r, pend_nxt;
  logic                    hit_r, hit_nxt;
  logic                    is_sort_r, is_sort_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic signed [VAL_W-1:0] best_r, best_nxt;
  logic                    have_r, have_nxt;
  logic [CNT_W-1:0]        mult_r, mult_nxt;
  logic [CNT_W-1:0]        emitted_r, emitted_nxt;
  logic signed [VAL_W-1:0] thresh_r, thresh_nxt;
  logic                    thresh_vld_r, thresh_vld_nxt;
  logic [STAT_W-1:0]       res_status_r, res_status_nxt;
  logic                    res_found_r, res_found_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       out_status_r;
  logic                    out_found_r;
  logic signed [VAL_W-1:0] out_item_r;
  logic                    out_last_r;

  logic                    ld;
  logic [STAT_W-1:0]       ld_status;
  logic                    ld_found;
  logic signed [VAL_W-1:0] ld_item;
  logic                    ld_last;
  logic                    out_free;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic signed [VAL_W-1:0] ram_rdata;
  logic signed [VAL_W-1:0] elem;
  logic                    qual;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(k);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  cqss_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (key_nxt),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign elem     = ram_rdata;
  assign qual     = !thresh_vld_r || (elem < thresh_r);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    hit_nxt        = hit_r;
    is_sort_nxt    = is_sort_r;
    key_nxt        = key_r;
    best_nxt       = best_r;
    have_nxt       = have_r;
    mult_nxt       = mult_r;
    emitted_nxt    = emitted_r;
    thresh_nxt     = thresh_r;
    thresh_vld_nxt = thresh_vld_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    cmd_take       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = slot_of(head_r, count_r);
    ram_re         = 1'b0;
    ram_raddr      = slot_of(head_r, idx_r);
    ld             = 1'b0;
    ld_status      = ST_OK;
    ld_found       = 1'b0;
    ld_item        = '0;
    ld_last        = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take       = 1'b1;
          key_nxt        = cmd.value;
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          idx_nxt        = '0;
          hit_nxt        = 1'b0;
          have_nxt       = 1'b0;
          emitted_nxt    = '0;
          thresh_vld_nxt = 1'b0;
          is_sort_nxt    = (cmd.op == OP_SORT);
          state_nxt      = S_RESULT;
          unique case (cmd.op)
            OP_INSERT: begin
              if (count_r == CNT_W'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                head_nxt  = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_SEARCH, OP_SORT: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_TRAVERSE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_TRAV_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (idx_r < count_r) begin
          ram_re   = 1'b1;
          idx_nxt  = idx_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (elem == key_r) begin
            hit_nxt = 1'b1;
          end
          if (qual) begin
            if (!have_r || elem > best_r) begin
              best_nxt = elem;
              mult_nxt = CNT_W'(1);
              have_nxt = 1'b1;
            end else if (elem == best_r) begin
              mult_nxt = mult_r + CNT_W'(1);
            end
          end
        end
        if (idx_r == count_r && !pend_r) begin
          if (is_sort_r) begin
            state_nxt = S_SORT_EMIT;
          end else begin
            res_found_nxt = hit_r;
            state_nxt     = S_RESULT;
          end
        end
      end

      S_TRAV_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_TRAV_EMIT;
      end

      S_TRAV_EMIT: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_item = ram_rdata;
          ld_last = (idx_r + CNT_W'(1) == count_r);
          idx_nxt = idx_r + CNT_W'(1);
          state_nxt = ld_last ? S_IDLE : S_TRAV_RD;
        end
      end

      S_SORT_EMIT: begin
        if (out_free) begin
          ld          = 1'b1;
          ld_item     = best_r;
          ld_last     = (emitted_r + CNT_W'(1) == count_r);
          emitted_nxt = emitted_r + CNT_W'(1);
          mult_nxt    = mult_r - CNT_W'(1);
          if (ld_last) begin
            state_nxt = S_IDLE;
          end else if (mult_r == CNT_W'(1)) begin
            // next smaller distinct value
            thresh_nxt     = best_r;
            thresh_vld_nxt = 1'b1;
            have_nxt       = 1'b0;
            idx_nxt        = '0;
            state_nxt      = S_SCAN;
          end
        end
      end

      S_RESULT: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_status = res_status_r;
          ld_found  = res_found_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    is_sort_r    <= is_sort_nxt;
    key_r        <= key_nxt;
    best_r       <= best_nxt;
    have_r       <= have_nxt;
    mult_r       <= mult_nxt;
    emitted_r    <= emitted_nxt;
    thresh_r     <= thresh_nxt;
    thresh_vld_r <= thresh_vld_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    if (ld) begin
      out_status_r <= ld_status;
      out_found_r  <= ld_found;
      out_item_r   <= ld_item;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_found      = out_found_r;
  assign out_item_value = out_item_r;
  assign out_last       = out_last_r;
  assign stat           = '{head: head_r, count: count_r};

endmodule

`default_nettype wire

// ===== sv/circular_queue_search_sort.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded circular queue of signed 32-bit values, 16 entries deep, held in a
// single-port-read RAM. Requests enter a two-entry command queue and are
// carried out one at a time by the back end; results leave through an output
// register, so up to three further requests are taken while a result waits.
// Insert, delete, unused codes and any request on an empty queue go straight
// to a single result. Search reads every stored entry once. Traverse reads
// each entry and emits it before it reads the next. The sorted dump does one
// full pass over the stored entries per distinct value, then emits all copies
// of that value, one per cycle while the output is not stalled. The RAM gives
// at most one read per cycle, and a stalled output holds up every request.

module circular_queue_search_sort (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [cqss_pkg::FUNC_W-1:0]        in_func,
  input  wire logic signed [cqss_pkg::VAL_W-1:0]  in_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [cqss_pkg::STAT_W-1:0]             out_status,
  output logic                                    out_found,
  output logic signed [cqss_pkg::VAL_W-1:0]       out_item_value,
  output logic                                    out_last
);

  import cqss_pkg::*;

  logic     cmd_valid;
  cmd_t     cmd;
  logic     cmd_take;
  bk_stat_t stat;

  cqss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_value  (in_value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  cqss_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_take       (cmd_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_item_value (out_item_value),
    .out_last       (out_last),
    .stat           (stat)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= CNT_W'(DEPTH))
    else $error("item count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (stat.count == $past(stat.count) ||
                      stat.count == $past(stat.count) + CNT_W'(1) ||
                      stat.count + CNT_W'(1) == $past(stat.count)))
    else $error("item count moved by more than one");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_item_value == '0 && !out_found)
    else $error("error result is not a single empty transfer");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK && out_last)
    else $error("found set on a non-search result");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cqss_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 64;
  localparam int PHASE_ITEMS   = 50;
  localparam int MAX_PRINTS    = 60;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] value;
  } request_t;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic                    found;
    logic signed [VAL_W-1:0] item_value;
    logic                    last;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [FUNC_W-1:0]       in_func = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STAT_W-1:0]       out_status;
  logic                    out_found;
  logic signed [VAL_W-1:0] out_item_value;
  logic                    out_last;

  // shadow of the queue contents, updated on each accepted transfer
  logic signed [VAL_W-1:0] model_store [DEPTH];
  int model_head = 0;
  int model_count = 0;

  queue_result_t expected_results [$];
  request_t      pending_requests [$];
  request_t      next_req;

  // contents as the stimulus generator expects them to be, for search hits
  logic signed [VAL_W-1:0] planned_values [$];
  int requests_planned = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int phase_idx = -1;
  logic hold_off = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;

  circular_queue_search_sort dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_item_value (out_item_value),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic add_expected_result(input logic [STAT_W-1:0] status, input logic found,
                                     input logic signed [VAL_W-1:0] item_value,
                                     input logic last);
    queue_result_t r;
    r.status = status;
    r.found = found;
    r.item_value = item_value;
    r.last = last;
    expected_results.push_back(r);
  endtask

  task automatic apply_request(input logic [FUNC_W-1:0] func,
                               input logic signed [VAL_W-1:0] value);
    logic signed [VAL_W-1:0] ordered [DEPTH];
    logic signed [VAL_W-1:0] tmp;
    logic hit;
    int i;
    int j;
    hit = 1'b0;
    case (func)
      FN_INSERT: begin
        if (model_count >= DEPTH) begin
          add_expected_result(ST_FULL, 1'b0, '0, 1'b1);
        end else begin
          model_store[(model_head + model_count) % DEPTH] = value;
          model_count++;
          add_expected_result(ST_OK, 1'b0, '0, 1'b1);
        end
      end
      FN_DELETE: begin
        if (model_count == 0) begin
          add_expected_result(ST_EMPTY, 1'b0, '0, 1'b1);
        end else begin
          model_head = (model_head + 1) % DEPTH;
          model_count--;
          add_expected_result(ST_OK, 1'b0, '0, 1'b1);
        end
      end
      FN_SEARCH: begin
        if (model_count == 0) begin
          add_expected_result(ST_EMPTY, 1'b0, '0, 1'b1);
        end else begin
          for (i = 0; i < model_count; i++) begin
            if (model_store[(model_head + i) % DEPTH] == value) hit = 1'b1;
          end
          add_expected_result(ST_OK, hit, '0, 1'b1);
        end
      end
      FN_TRAVERSE: begin
        if (model_count == 0) begin
          add_expected_result(ST_EMPTY, 1'b0, '0, 1'b1);
        end else begin
          for (i = 0; i < model_count; i++) begin
            add_expected_result(ST_OK, 1'b0, model_store[(model_head + i) % DEPTH],
                                i == model_count - 1);
          end
        end
      end
      FN_SORT: begin
        if (model_count == 0) begin
          add_expected_result(ST_EMPTY, 1'b0, '0, 1'b1);
        end else begin
          for (i = 0; i < model_count; i++) ordered[i] = model_store[(model_head + i) % DEPTH];
          for (i = 0; i < model_count; i++) begin
            for (j = i + 1; j < model_count; j++) begin
              if (ordered[j] > ordered[i]) begin
                tmp = ordered[i];
                ordered[i] = ordered[j];
                ordered[j] = tmp;
              end
            end
          end
          for (i = 0; i < model_count; i++) begin
            add_expected_result(ST_OK, 1'b0, ordered[i], i == model_count - 1);
          end
        end
      end
      default: begin
        add_expected_result(ST_OK, 1'b0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic add_request(input logic [FUNC_W-1:0] func,
                             input logic signed [VAL_W-1:0] value);
    request_t r;
    r.func = func;
    r.value = value;
    pending_requests.push_back(r);
    requests_planned++;
    if (func == FN_INSERT && planned_values.size() < DEPTH) begin
      planned_values.push_back(value);
    end else if (func == FN_DELETE && planned_values.size() != 0) begin
      void'(planned_values.pop_front());
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return VAL_MAX;
    if (r == 1) return VAL_MIN;
    if (r < 5) return int'($urandom_range(8)) - 4;
    return $urandom;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_search_value();
    int unsigned r;
    r = $urandom_range(9);
    if (planned_values.size() == 0 || r < 3) return pick_value();
    if (r == 3) return planned_values[planned_values.size() - 1];
    if (r == 4) return planned_values[0];
    return planned_values[$urandom_range(planned_values.size() - 1)];
  endfunction

  task automatic add_directed();
    add_request(FN_TRAVERSE, '0);
    add_request(FN_SORT, VAL_MAX);
    add_request(FN_SEARCH, '0);
    add_request(FN_DELETE, VAL_MIN);
    add_request(FN_INSERT, VAL_MAX);
    add_request(FN_INSERT, VAL_MIN);
    add_request(FN_INSERT, -1);
    add_request(FN_INSERT, 0);
    add_request(FN_INSERT, 1);
    add_request(FN_SEARCH, VAL_MAX);
    add_request(FN_SEARCH, 1);
    add_request(FN_SEARCH, 12345);
    add_request(FN_TRAVERSE, '0);
    add_request(FN_SORT, '0);
    add_request(FN_SPARE_FIRST, VAL_MAX);
    add_request(FN_SPARE_FIRST + 3'd1, -1);
    add_request(FN_SPARE_LAST, VAL_MIN);
    add_request(FN_DELETE, '0);
    add_request(FN_DELETE, '0);
  endtask

  task automatic add_random(input int n);
    int target;
    int kind;
    int k;
    int unsigned r;
    target = requests_planned + n;
    while (requests_planned < target) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        // fill to the brim and up to two past it, search, then dump
        k = DEPTH - planned_values.size() + $urandom_range(2);
        repeat (k) add_request(FN_INSERT, pick_value());
        add_request(FN_SEARCH, pick_search_value());
        add_request($urandom_range(1) ? FN_SORT : FN_TRAVERSE, pick_value());
      end else if (kind < 3) begin
        k = planned_values.size() + $urandom_range(1, 2);
        repeat (k) add_request(FN_DELETE, pick_value());
        add_request(FN_SEARCH, pick_value());
      end else if (kind < 9) begin
        repeat ($urandom_range(3, 8)) begin
          r = $urandom_range(99);
          if (r < 35) add_request(FN_INSERT, pick_value());
          else if (r < 55) add_request(FN_DELETE, pick_value());
          else if (r < 80) add_request(FN_SEARCH, pick_search_value());
          else if (r < 90) add_request(FN_TRAVERSE, pick_value());
          else add_request(FN_SORT, pick_value());
        end
      end else begin
        add_request(FUNC_W'($urandom_range(FN_SPARE_LAST)), $urandom);
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_request(in_func, in_value);
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_func <= next_req.func;
          in_value <= next_req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer status=%0d found=%0d value=%0d last=%0d",
                                    out_status, out_found, out_item_value, out_last));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", out_status, want.status));
          if (out_found !== want.found)
            report_mismatch($sformatf("found %0d, wanted %0d", out_found, want.found));
          if (out_item_value !== want.item_value)
            report_mismatch($sformatf("item_value %0d, wanted %0d",
                                      out_item_value, want.item_value));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0d, wanted %0d", out_last, want.last));
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (phase_idx == 2);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("circular_queue_search_sort test failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 16;
          recv_stall_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_stall_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_idx = p;
      if (p == 0) add_directed();
      add_random(PHASE_ITEMS);
      @(negedge clk);
      while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
        @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("circular_queue_search_sort test passed");
    end else begin
      $display("circular_queue_search_sort test failed");
    end
    $finish;
  end

endmodule
